// ===== design/dapps_pkg.sv =====
// shared types and constants for the dual adc pressure poll sequencer
package dapps_pkg;

    localparam int GAIN_FRACTION_BITS = 12;
    localparam int BYTE_W = 8;
    localparam int SAMPLE_W = 2 * BYTE_W;
    localparam int GAIN_W = 16;
    localparam int MEAS_W = 20;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_W = 2;

    localparam logic [BYTE_W-1:0] ABS_ADDR = 8'h90;
    localparam logic [BYTE_W-1:0] DIFF_ADDR = 8'h92;
    localparam logic [BYTE_W-1:0] GCALL_ADDR = 8'h00;
    localparam logic [BYTE_W-1:0] GCALL_RESET = 8'h06;
    localparam logic [BYTE_W-1:0] REG_CONFIG = 8'h01;
    localparam logic [BYTE_W-1:0] REG_CONVERSION = 8'h00;
    localparam logic [BYTE_W-1:0] CONFIG_LOW = 8'h83;
    localparam logic [BYTE_W-1:0] DIFF_CONFIG_HIGH = 8'h84;
    localparam logic [BYTE_W-1:0] ABS_CONFIG_HIGH_RESET = 8'h86;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_ABS_CONFIG_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_DONE = 1'b1;

    typedef enum logic [1:0] {
        KIND_XFER = 2'd0,
        KIND_ABS  = 2'd1,
        KIND_DIFF = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        XFER_WRITE      = 2'd0,
        XFER_READ       = 2'd1,
        XFER_WRITE_READ = 2'd2
    } xfer_t;

    typedef struct packed {
        logic valid;
        logic command;
        logic bus_idle;
        logic transfer_ok;
    } seq_in_t;

    typedef struct packed {
        logic              emit;
        kind_t             kind;
        xfer_t             xfer_type;
        logic [BYTE_W-1:0] slave_address;
        logic [LEN_W-1:0]  write_length;
        logic [LEN_W-1:0]  read_length;
        logic [BYTE_W-1:0] write_byte0;
        logic [BYTE_W-1:0] write_byte1;
        logic [BYTE_W-1:0] write_byte2;
        logic              running;
    } seq_out_t;

endpackage

// ===== design/dapps_seq.sv =====
// phase sequencer: transaction descriptors and completion handling
module dapps_seq
    import dapps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  seq_in_t           seq_in,
    input  logic              fire,
    input  logic [BYTE_W-1:0] abs_config_high,
    output seq_out_t          seq_out
);

    typedef enum logic [10:0] {
        PH_UNINIT       = 11'b000_0000_0001,
        PH_RESET_SENT   = 11'b000_0000_0010,
        PH_ABS_CFG      = 11'b000_0000_0100,
        PH_ABS_PTR      = 11'b000_0000_1000,
        PH_DIFF_CFG     = 11'b000_0001_0000,
        PH_DIFF_PTR     = 11'b000_0010_0000,
        PH_IDLE         = 11'b000_0100_0000,
        PH_READING_ABS  = 11'b000_1000_0000,
        PH_READ_ABS     = 11'b001_0000_0000,
        PH_READING_DIFF = 11'b010_0000_0000,
        PH_READ_DIFF    = 11'b100_0000_0000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   running_reg, running_next;
    seq_out_t res;

    always_comb begin
        phase_next = phase_reg;
        running_next = running_reg;
        res = '0;
        res.kind = KIND_XFER;
        res.xfer_type = XFER_WRITE;
        if (seq_in.valid) begin
            if (seq_in.command == CMD_TICK) begin
                if (seq_in.bus_idle) begin
                    case (phase_reg)
                        PH_UNINIT: begin
                            res.emit = 1'b1;
                            res.slave_address = GCALL_ADDR;
                            res.write_length = 2'd1;
                            res.write_byte0 = GCALL_RESET;
                            phase_next = PH_RESET_SENT;
                        end
                        PH_RESET_SENT: begin
                            res.emit = 1'b1;
                            res.slave_address = ABS_ADDR;
                            res.write_length = 2'd3;
                            res.write_byte0 = REG_CONFIG;
                            res.write_byte1 = abs_config_high;
                            res.write_byte2 = CONFIG_LOW;
                            phase_next = PH_ABS_CFG;
                        end
                        PH_ABS_CFG: begin
                            res.emit = 1'b1;
                            res.slave_address = ABS_ADDR;
                            res.write_length = 2'd1;
                            res.write_byte0 = REG_CONVERSION;
                            phase_next = PH_ABS_PTR;
                        end
                        PH_ABS_PTR: begin
                            res.emit = 1'b1;
                            res.slave_address = DIFF_ADDR;
                            res.write_length = 2'd3;
                            res.write_byte0 = REG_CONFIG;
                            res.write_byte1 = DIFF_CONFIG_HIGH;
                            res.write_byte2 = CONFIG_LOW;
                            phase_next = PH_DIFF_CFG;
                        end
                        PH_DIFF_CFG: begin
                            res.emit = 1'b1;
                            res.slave_address = DIFF_ADDR;
                            res.write_length = 2'd1;
                            res.write_byte0 = REG_CONVERSION;
                            phase_next = PH_DIFF_PTR;
                        end
                        PH_DIFF_PTR, PH_READ_DIFF: begin
                            res.emit = 1'b1;
                            res.xfer_type = XFER_READ;
                            res.slave_address = ABS_ADDR;
                            res.read_length = 2'd2;
                            running_next = 1'b1;
                            phase_next = PH_READING_ABS;
                        end
                        PH_READ_ABS: begin
                            res.emit = 1'b1;
                            res.xfer_type = XFER_READ;
                            res.slave_address = DIFF_ADDR;
                            res.read_length = 2'd2;
                            phase_next = PH_READING_DIFF;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end else begin
                case (phase_reg)
                    PH_READING_ABS: begin
                        res.emit = seq_in.transfer_ok;
                        res.kind = KIND_ABS;
                        phase_next = PH_READ_ABS;
                    end
                    PH_READING_DIFF: begin
                        res.emit = seq_in.transfer_ok;
                        res.kind = KIND_DIFF;
                        phase_next = PH_READ_DIFF;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        res.running = running_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_UNINIT;
            running_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            running_reg <= running_next;
        end
    end

    assign seq_out = res;

    // running flag never drops once set
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |=> running_reg)
        else $error("running flag cleared");

    // a measurement only comes out of a read in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.emit && res.kind != KIND_XFER) |->
        (phase_reg == PH_READING_ABS || phase_reg == PH_READING_DIFF))
        else $error("measurement without outstanding read");

    // no read is issued before the setup sequence has run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.emit && res.xfer_type == XFER_READ) |-> res.running)
        else $error("read issued while not running");

    // the phase moves only when a word is consumed
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(phase_reg))
        else $error("phase changed without a word");

endmodule

// ===== design/dapps_scale.sv =====
// sample scaling: signed big-endian sample times unsigned q4.12 gain
module dapps_scale
    import dapps_pkg::*;
(
    input  logic [BYTE_W-1:0]        data_high,
    input  logic [BYTE_W-1:0]        data_low,
    input  logic [GAIN_W-1:0]        gain,
    output logic signed [MEAS_W-1:0] measurement
);

    localparam int PROD_W = SAMPLE_W + GAIN_W + 2;
    localparam logic signed [PROD_W-1:0] MEAS_MAX = PROD_W'((64'sd1 <<< (MEAS_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] MEAS_MIN = -(PROD_W'(64'sd1 <<< (MEAS_W - 1)));

    logic signed [SAMPLE_W:0] raw;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] shifted;

    always_comb begin
        raw = {data_high[BYTE_W-1], data_high, data_low};
        gain_s = {1'b0, gain};
        prod = PROD_W'(raw) * PROD_W'(gain_s);
        shifted = prod >>> GAIN_FRACTION_BITS;
        if (shifted > MEAS_MAX) begin
            measurement = MEAS_MAX[MEAS_W-1:0];
        end else if (shifted < MEAS_MIN) begin
            measurement = MEAS_MIN[MEAS_W-1:0];
        end else begin
            measurement = shifted[MEAS_W-1:0];
        end
    end

endmodule

// ===== design/dual_adc_pressure_poll_sequencer.sv =====
// top level of the dual adc pressure poll sequencer
//
// input words arrive on the s_ channel: a periodic tick (command 0, with
// bus_idle) or a bus transfer completion (command 1, with transfer_ok, the
// two received bytes and the current time). result words leave on the m_
// channel: either a transaction descriptor for the i2c master or a scaled
// absolute or differential pressure measurement.
// a word passes an input register, the phase logic and one 17x17 multiply,
// then lands in the output register. one word is taken every cycle while
// the output register drains; the phase and running registers are the only
// state carried from word to word and they update as a word leaves the
// input register. words that cause no result are consumed silently.
// when m_ready is low the output register holds its word and the input
// register holds one more; s_ready drops only when both are full.
// reset (aresetn low, synchronous) empties both registers, returns the phase
// to the general-call step, clears running and restores the config
// registers. cfg_we writes one register per cycle, with no wait.
module dual_adc_pressure_poll_sequencer
    import dapps_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_command,
    input  logic                     s_bus_idle,
    input  logic                     s_transfer_ok,
    input  logic [BYTE_W-1:0]        s_data_high,
    input  logic [BYTE_W-1:0]        s_data_low,
    input  logic [TIME_W-1:0]        s_time_us,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_out_kind,
    output logic [1:0]               m_xfer_type,
    output logic [BYTE_W-1:0]        m_slave_address,
    output logic [LEN_W-1:0]         m_write_length,
    output logic [LEN_W-1:0]         m_read_length,
    output logic [BYTE_W-1:0]        m_write_byte0,
    output logic [BYTE_W-1:0]        m_write_byte1,
    output logic [BYTE_W-1:0]        m_write_byte2,
    output logic signed [MEAS_W-1:0] m_measurement,
    output logic [TIME_W-1:0]        m_timestamp_us,
    output logic                     m_running
);

    logic [BYTE_W-1:0] abs_config_high_reg;
    logic [GAIN_W-1:0] abs_gain_reg;
    logic [GAIN_W-1:0] diff_gain_reg;

    logic              in_valid_reg;
    logic              command_reg;
    logic              bus_idle_reg;
    logic              transfer_ok_reg;
    logic [BYTE_W-1:0] data_high_reg;
    logic [BYTE_W-1:0] data_low_reg;
    logic [TIME_W-1:0] time_us_reg;

    logic                     out_valid_reg;
    seq_out_t                 out_desc_reg;
    logic signed [MEAS_W-1:0] out_meas_reg;
    logic [TIME_W-1:0]        out_time_reg;

    logic                     fire;
    seq_in_t                  seq_in;
    seq_out_t                 seq_out;
    logic [GAIN_W-1:0]        gain_sel;
    logic signed [MEAS_W-1:0] scaled;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            abs_config_high_reg <= ABS_CONFIG_HIGH_RESET;
            abs_gain_reg <= GAIN_UNITY;
            diff_gain_reg <= GAIN_UNITY;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ABS_CONFIG_HIGH: abs_config_high_reg <= cfg_wdata[BYTE_W-1:0];
                CFG_ABS_GAIN:        abs_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_DIFF_GAIN:       diff_gain_reg <= cfg_wdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            command_reg <= s_command;
            bus_idle_reg <= s_bus_idle;
            transfer_ok_reg <= s_transfer_ok;
            data_high_reg <= s_data_high;
            data_low_reg <= s_data_low;
            time_us_reg <= s_time_us;
        end
    end

    always_comb begin
        seq_in.valid = in_valid_reg;
        seq_in.command = command_reg;
        seq_in.bus_idle = bus_idle_reg;
        seq_in.transfer_ok = transfer_ok_reg;
    end

    dapps_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .seq_in          (seq_in),
        .fire            (fire),
        .abs_config_high (abs_config_high_reg),
        .seq_out         (seq_out)
    );

    assign gain_sel = (seq_out.kind == KIND_ABS) ? abs_gain_reg : diff_gain_reg;

    dapps_scale u_scale (
        .data_high   (data_high_reg),
        .data_low    (data_low_reg),
        .gain        (gain_sel),
        .measurement (scaled)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= seq_out.emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && seq_out.emit) begin
            out_desc_reg <= seq_out;
            out_meas_reg <= (seq_out.kind == KIND_XFER) ? '0 : scaled;
            out_time_reg <= (seq_out.kind == KIND_ABS) ? time_us_reg : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_out_kind = out_desc_reg.kind;
    assign m_xfer_type = out_desc_reg.xfer_type;
    assign m_slave_address = out_desc_reg.slave_address;
    assign m_write_length = out_desc_reg.write_length;
    assign m_read_length = out_desc_reg.read_length;
    assign m_write_byte0 = out_desc_reg.write_byte0;
    assign m_write_byte1 = out_desc_reg.write_byte1;
    assign m_write_byte2 = out_desc_reg.write_byte2;
    assign m_measurement = out_meas_reg;
    assign m_timestamp_us = out_time_reg;
    assign m_running = out_desc_reg.running;

endmodule

// ===== verif/dual_adc_pressure_poll_sequencer_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the dual adc pressure poll sequencer: queued driver, checking monitor
module dual_adc_pressure_poll_sequencer_tb;
    import dapps_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int RESET_CYCLES = 10;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_WORDS = 280;
    localparam int MAX_REPORTS = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [3:0] {
        SEQ_GCALL,
        SEQ_RESET_SENT,
        SEQ_ABS_CFG,
        SEQ_ABS_PTR,
        SEQ_DIFF_CFG,
        SEQ_DIFF_PTR,
        SEQ_NO_ACTION,
        SEQ_ABS_PENDING,
        SEQ_ABS_READ,
        SEQ_DIFF_PENDING,
        SEQ_DIFF_READ
    } seq_phase_t;

    typedef struct packed {
        logic              command;
        logic              bus_idle;
        logic              transfer_ok;
        logic [BYTE_W-1:0] data_high;
        logic [BYTE_W-1:0] data_low;
        logic [TIME_W-1:0] time_us;
    } poll_word_t;

    typedef struct packed {
        kind_t                    kind;
        xfer_t                    xfer_type;
        logic [BYTE_W-1:0]        slave_address;
        logic [LEN_W-1:0]         write_length;
        logic [LEN_W-1:0]         read_length;
        logic [BYTE_W-1:0]        write_byte0;
        logic [BYTE_W-1:0]        write_byte1;
        logic [BYTE_W-1:0]        write_byte2;
        logic signed [MEAS_W-1:0] measurement;
        logic [TIME_W-1:0]        timestamp_us;
        logic                     running;
    } poll_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_command = 1'b0;
    logic                     s_bus_idle = 1'b0;
    logic                     s_transfer_ok = 1'b0;
    logic [BYTE_W-1:0]        s_data_high = '0;
    logic [BYTE_W-1:0]        s_data_low = '0;
    logic [TIME_W-1:0]        s_time_us = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_out_kind;
    logic [1:0]               m_xfer_type;
    logic [BYTE_W-1:0]        m_slave_address;
    logic [LEN_W-1:0]         m_write_length;
    logic [LEN_W-1:0]         m_read_length;
    logic [BYTE_W-1:0]        m_write_byte0;
    logic [BYTE_W-1:0]        m_write_byte1;
    logic [BYTE_W-1:0]        m_write_byte2;
    logic signed [MEAS_W-1:0] m_measurement;
    logic [TIME_W-1:0]        m_timestamp_us;
    logic                     m_running;

    dual_adc_pressure_poll_sequencer dut (.*);

    always #(CLK_HALF) aclk = ~aclk;

    // predictor state and its copy of the config registers
    seq_phase_t        seq_phase;
    logic              running_flag;
    logic [BYTE_W-1:0] abs_cfg_high;
    logic [GAIN_W-1:0] abs_gain_q;
    logic [GAIN_W-1:0] diff_gain_q;

    poll_word_t   pending_words[$];
    poll_result_t expected_results[$];

    int words_accepted = 0;
    int results_checked = 0;
    int abs_seen = 0;
    int diff_seen = 0;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    logic holdoff_req = 1'b0;
    logic holdoff_started = 1'b0;

    function automatic logic signed [MEAS_W-1:0] scale_sample(input logic [BYTE_W-1:0] hi,
                                                              input logic [BYTE_W-1:0] lo,
                                                              input logic [GAIN_W-1:0] gain);
        logic signed [SAMPLE_W-1:0] raw;
        longint product;
        raw = {hi, lo};
        product = longint'(raw) * longint'(gain);
        return MEAS_W'(product >>> GAIN_FRACTION_BITS);
    endfunction

    function automatic bit predict_poll(input poll_word_t w, output poll_result_t r);
        r = '0;
        if (w.command == CMD_TICK) begin
            if (!w.bus_idle) return 1'b0;
            case (seq_phase)
                SEQ_GCALL: begin
                    r.slave_address = GCALL_ADDR;
                    r.write_length = 2'd1;
                    r.write_byte0 = GCALL_RESET;
                    seq_phase = SEQ_RESET_SENT;
                end
                SEQ_RESET_SENT: begin
                    r.slave_address = ABS_ADDR;
                    r.write_length = 2'd3;
                    r.write_byte0 = REG_CONFIG;
                    r.write_byte1 = abs_cfg_high;
                    r.write_byte2 = CONFIG_LOW;
                    seq_phase = SEQ_ABS_CFG;
                end
                SEQ_ABS_CFG: begin
                    r.slave_address = ABS_ADDR;
                    r.write_length = 2'd1;
                    r.write_byte0 = REG_CONVERSION;
                    seq_phase = SEQ_ABS_PTR;
                end
                SEQ_ABS_PTR: begin
                    r.slave_address = DIFF_ADDR;
                    r.write_length = 2'd3;
                    r.write_byte0 = REG_CONFIG;
                    r.write_byte1 = DIFF_CONFIG_HIGH;
                    r.write_byte2 = CONFIG_LOW;
                    seq_phase = SEQ_DIFF_CFG;
                end
                SEQ_DIFF_CFG: begin
                    r.slave_address = DIFF_ADDR;
                    r.write_length = 2'd1;
                    r.write_byte0 = REG_CONVERSION;
                    seq_phase = SEQ_DIFF_PTR;
                end
                SEQ_DIFF_PTR, SEQ_DIFF_READ: begin
                    running_flag = 1'b1;
                    r.xfer_type = XFER_READ;
                    r.slave_address = ABS_ADDR;
                    r.read_length = 2'd2;
                    seq_phase = SEQ_ABS_PENDING;
                end
                SEQ_ABS_READ: begin
                    r.xfer_type = XFER_READ;
                    r.slave_address = DIFF_ADDR;
                    r.read_length = 2'd2;
                    seq_phase = SEQ_DIFF_PENDING;
                end
                default: return 1'b0;
            endcase
            r.kind = KIND_XFER;
            r.running = running_flag;
            return 1'b1;
        end
        if (seq_phase == SEQ_ABS_PENDING) begin
            seq_phase = SEQ_ABS_READ;
            if (!w.transfer_ok) return 1'b0;
            r.kind = KIND_ABS;
            r.measurement = scale_sample(w.data_high, w.data_low, abs_gain_q);
            r.timestamp_us = w.time_us;
            r.running = running_flag;
            return 1'b1;
        end
        if (seq_phase == SEQ_DIFF_PENDING) begin
            seq_phase = SEQ_DIFF_READ;
            if (!w.transfer_ok) return 1'b0;
            r.kind = KIND_DIFF;
            r.measurement = scale_sample(w.data_high, w.data_low, diff_gain_q);
            r.running = running_flag;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic string show_result(input poll_result_t p);
        return $sformatf("kind %0d type %0d addr %h len %0d/%0d bytes %h %h %h meas %0d ts %h run %b",
                         p.kind, p.xfer_type, p.slave_address, p.write_length, p.read_length,
                         p.write_byte0, p.write_byte1, p.write_byte2, p.measurement,
                         p.timestamp_us, p.running);
    endfunction

    function automatic poll_word_t make_word(input logic command, input logic idle,
                                             input logic ok, input logic [BYTE_W-1:0] hi,
                                             input logic [BYTE_W-1:0] lo,
                                             input logic [TIME_W-1:0] stamp);
        poll_word_t w;
        w.command = command;
        w.bus_idle = idle;
        w.transfer_ok = ok;
        w.data_high = hi;
        w.data_low = lo;
        w.time_us = stamp;
        return w;
    endfunction

    function automatic poll_word_t random_word(input logic command);
        poll_word_t w;
        w.command = command;
        w.bus_idle = 1'($urandom_range(1));
        w.transfer_ok = 1'($urandom_range(1));
        w.data_high = 8'($urandom);
        w.data_low = 8'($urandom);
        w.time_us = $urandom;
        // lean on the sign boundary now and then
        if ($urandom_range(7) == 0) w.data_high = $urandom_range(1) ? 8'h80 : 8'h7F;
        return w;
    endfunction

    // mostly tick/finish pairs that keep the reads going, the rest noise
    task automatic queue_random_words(input int count);
        int made;
        poll_word_t w;
        made = 0;
        while (made < count) begin
            if ($urandom_range(99) < 80) begin
                w = random_word(CMD_TICK);
                w.bus_idle = 1'b1;
                pending_words.push_back(w);
                w = random_word(CMD_DONE);
                w.transfer_ok = ($urandom_range(9) != 0);
                pending_words.push_back(w);
                made += 2;
            end else begin
                pending_words.push_back(random_word(1'($urandom_range(1))));
                made++;
            end
        end
    endtask

    task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_ABS_CONFIG_HIGH: abs_cfg_high = value[BYTE_W-1:0];
            CFG_ABS_GAIN:        abs_gain_q = value;
            CFG_DIFF_GAIN:       diff_gain_q = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge aclk);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        poll_word_t accepted_word;
        poll_word_t next_word;
        poll_result_t predicted;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                words_accepted++;
                accepted_word = {s_command, s_bus_idle, s_transfer_ok,
                                 s_data_high, s_data_low, s_time_us};
                if (predict_poll(accepted_word, predicted)) expected_results.push_back(predicted);
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_command <= next_word.command;
                    s_bus_idle <= next_word.bus_idle;
                    s_transfer_ok <= next_word.transfer_ok;
                    s_data_high <= next_word.data_high;
                    s_data_low <= next_word.data_low;
                    s_time_us <= next_word.time_us;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        poll_result_t observed;
        poll_result_t wanted;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                observed = {m_out_kind, m_xfer_type, m_slave_address, m_write_length,
                            m_read_length, m_write_byte0, m_write_byte1, m_write_byte2,
                            m_measurement, m_timestamp_us, m_running};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("[%0t] unexpected word: %s", $time, show_result(observed));
                end else begin
                    wanted = expected_results.pop_front();
                    results_checked++;
                    if (wanted.kind == KIND_ABS) abs_seen++;
                    if (wanted.kind == KIND_DIFF) diff_seen++;
                    if (observed !== wanted) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("[%0t] mismatch", $time);
                            $display("  expected %s", show_result(wanted));
                            $display("  actual   %s", show_result(observed));
                        end
                    end
                end
            end
            m_ready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
            holdoff_started <= 1'b0;
        end else if (holdoff_req && !holdoff_started) begin
            hold_cycles <= HOLDOFF_CYCLES;
            holdoff_started <= 1'b1;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        seq_phase = SEQ_GCALL;
        running_flag = 1'b0;
        abs_cfg_high = ABS_CONFIG_HIGH_RESET;
        abs_gain_q = GAIN_UNITY;
        diff_gain_q = GAIN_UNITY;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        write_config(CFG_ABS_CONFIG_HIGH, 16'h0084);
        set_idling(0, 0);

        // init sequence, stray words, sign extremes, failed reads
        pending_words.push_back(make_word(CMD_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b1, 8'h12, 8'h34, 32'h1));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b0, 1'b1, 8'hFF, 8'hFF, 32'hFFFFFFFF));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b1, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b0, 1'b1, 8'h7F, 8'hFF, 32'hFFFFFFFF));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b1, 8'h55, 8'hAA, 32'h5));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b1, 8'h80, 8'h00, 32'hFFFFFFFF));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b0, 8'hFF, 8'hFF, 32'h7));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b0, 1'b1, 8'hFF, 8'hFF, 32'h8));
        pending_words.push_back(make_word(CMD_TICK, 1'b0, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b1, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_TICK, 1'b1, 1'b0, 8'h00, 8'h00, 32'h0));
        pending_words.push_back(make_word(CMD_DONE, 1'b1, 1'b0, 8'h80, 8'h01, 32'h9));
        wait_drained();

        queue_random_words(PHASE_WORDS);
        wait_drained();

        write_config(CFG_ABS_GAIN, 16'h0000);
        write_config(CFG_DIFF_GAIN, 16'hFFFF);
        set_idling(84, 0);
        queue_random_words(PHASE_WORDS);
        wait_drained();

        write_config(CFG_ABS_GAIN, 16'hFFFF);
        write_config(CFG_DIFF_GAIN, 16'h0000);
        set_idling(0, 84);
        queue_random_words(PHASE_WORDS);
        wait_drained();

        write_config(CFG_ABS_CONFIG_HIGH, 16'($urandom));
        write_config(CFG_SPARE, 16'($urandom));
        write_config(CFG_ABS_GAIN, 16'($urandom));
        write_config(CFG_DIFF_GAIN, 16'($urandom));
        set_idling(15, 15);
        queue_random_words(PHASE_WORDS);
        wait_drained();

        // receiver holds off while the sender keeps offering, then a full drain
        write_config(CFG_ABS_GAIN, 16'h1001);
        write_config(CFG_DIFF_GAIN, 16'($urandom) | 16'h0001);
        set_idling(0, 0);
        queue_random_words(PHASE_WORDS / 2);
        holdoff_req = 1'b1;
        wait_drained();
        set_idling(15, 15);
        queue_random_words(PHASE_WORDS / 2);
        wait_drained();

        if (expected_results.size() != 0) begin
            errors += expected_results.size();
            $display("%0d expected words never arrived", expected_results.size());
        end
        $display("checked %0d result words (%0d absolute, %0d differential) from %0d input words",
                 results_checked, abs_seen, diff_seen, words_accepted);
        $display("idling mixes, a long receiver hold-off and gains from 0 to 65535 were covered");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
